@@ rtl/core/vn3d_pkg.sv @@
// Shared widths and stage counts for the 3D vector normalizer.
package vn3d_pkg;

   localparam int DATA_W    = 32;              // Q16.16 in, Q2.30 out
   localparam int SUM_W     = 2 * DATA_W;      // Q32.32 sum of squares
   localparam int ROOT_W    = SUM_W / 2;       // length, Q16.16
   localparam int FRAC_BITS = 30;              // output fraction bits
   localparam int QUO_W     = FRAC_BITS + 1;   // quotient never exceeds 2^30
   localparam int NUM_COMP  = 3;

   localparam int SQRT_STAGES = ROOT_W;        // one root bit per stage
   localparam int DIV_STAGES  = QUO_W;         // one quotient bit per stage
   localparam int REM_W       = ROOT_W + 2;    // sqrt partial remainder

   localparam logic [DATA_W-1:0] MIN_LENGTH_RESET = DATA_W'(1);

   typedef logic [DATA_W-1:0] comp_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [ROOT_W-1:0] root_type;
   typedef logic [QUO_W-1:0]  quo_type;

endpackage

@@ rtl/core/vector_normalize_3d_unit.sv @@
// Pipelined 3D vector normalizer, Q16.16 in, Q2.30 unit vector out.
//
// Channels: req_* takes one vector (in_x, in_y, in_z) per word under
// valid/ready; rsp_* returns one word per vector: the unit vector and
// valid_res, or a zero vector with valid_res low when the length is below
// csr_min_length (or zero). csr_* writes min_length; write it only while
// the unit is empty.
//
// Pipeline order from req acceptance to rsp_valid: magnitude, square,
// sum, 32 square-root stages producing one root bit each, 31 divider
// stages producing one quotient bit each for all three components in
// parallel, output register. Throughput: one vector per cycle while the output is not held.
//
// Stall: the whole pipeline advances only when the output register is
// empty or being taken; req_ready = !rsp_valid || rsp_ready, so a held
// output freezes every stage, bubbles included, and nothing is lost or
// repeated.
// Reset: synchronous, clears all stage valid bits and sets min_length to 1.
module vector_normalize_3d_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [vn3d_pkg::DATA_W-1:0] req_in_x,
   input  logic signed [vn3d_pkg::DATA_W-1:0] req_in_y,
   input  logic signed [vn3d_pkg::DATA_W-1:0] req_in_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [vn3d_pkg::DATA_W-1:0] rsp_out_x,
   output logic signed [vn3d_pkg::DATA_W-1:0] rsp_out_y,
   output logic signed [vn3d_pkg::DATA_W-1:0] rsp_out_z,
   output logic                            rsp_valid_res,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vn3d_pkg::DATA_W-1:0]     csr_min_length
);
   import vn3d_pkg::*;

   logic     adv;
   comp_type min_length_ff;

   // front stages
   logic     vld_a_ff, vld_b_ff, vld_c_ff;
   comp_type req_comp [NUM_COMP];
   comp_type mag_a_in [NUM_COMP];
   comp_type mag_a_ff [NUM_COMP];
   logic     neg_a_ff [NUM_COMP];
   sum_type  sq_b_ff  [NUM_COMP];
   comp_type mag_b_ff [NUM_COMP];
   logic     neg_b_ff [NUM_COMP];
   comp_type mag_c_ff [NUM_COMP];
   logic     neg_c_ff [NUM_COMP];
   sum_type  sum_c_ff;

   // square-root stages, index 0 is the sum stage
   logic             rt_vld_ff  [SQRT_STAGES+1];
   sum_type          rt_v_ff    [SQRT_STAGES+1];
   logic [REM_W-1:0] rt_rem_ff  [SQRT_STAGES+1];
   root_type         rt_root_ff [SQRT_STAGES+1];
   comp_type         rt_mag_ff  [SQRT_STAGES+1][NUM_COMP];
   logic             rt_neg_ff  [SQRT_STAGES+1][NUM_COMP];

   // divider stages, index 0 is the last root stage
   logic          dv_vld_ff  [DIV_STAGES+1];
   logic          dv_fail_ff [DIV_STAGES+1];
   root_type      dv_len_ff  [DIV_STAGES+1];
   comp_type      dv_rem_ff  [DIV_STAGES+1][NUM_COMP];
   quo_type       dv_q_ff    [DIV_STAGES+1][NUM_COMP];
   logic          dv_neg_ff  [DIV_STAGES+1][NUM_COMP];

   logic     out_vld_ff, out_ok_ff;
   comp_type out_ff [NUM_COMP];
   comp_type out_in [NUM_COMP];

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
      end else if (csr_valid) begin
         min_length_ff <= csr_min_length;
      end
   end

   assign req_comp[0] = comp_type'(req_in_x);
   assign req_comp[1] = comp_type'(req_in_y);
   assign req_comp[2] = comp_type'(req_in_z);

   always_comb begin
      for (int k = 0; k < NUM_COMP; k++) begin
         mag_a_in[k] = req_comp[k][DATA_W-1] ? (~req_comp[k] + DATA_W'(1)) : req_comp[k];
      end
   end

   // magnitude, square, sum
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= req_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_COMP; k++) begin
            mag_a_ff[k] <= mag_a_in[k];
            neg_a_ff[k] <= req_comp[k][DATA_W-1];
            sq_b_ff[k]  <= SUM_W'(mag_a_ff[k]) * SUM_W'(mag_a_ff[k]);
            mag_b_ff[k] <= mag_a_ff[k];
            neg_b_ff[k] <= neg_a_ff[k];
            mag_c_ff[k] <= mag_b_ff[k];
            neg_c_ff[k] <= neg_b_ff[k];
         end
         // 3 * 2^62 still fits in 64 bits
         sum_c_ff <= sq_b_ff[0] + sq_b_ff[1] + sq_b_ff[2];
      end
   end

   always_comb begin
      rt_vld_ff[0]  = vld_c_ff;
      rt_v_ff[0]    = sum_c_ff;
      rt_rem_ff[0]  = '0;
      rt_root_ff[0] = '0;
      for (int k = 0; k < NUM_COMP; k++) begin
         rt_mag_ff[0][k] = mag_c_ff[k];
         rt_neg_ff[0][k] = neg_c_ff[k];
      end
   end

   // digit-by-digit square root, one root bit per stage
   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      logic [REM_W+1:0] rem_sh_in;
      logic [REM_W+1:0] trial_in;
      logic             take_in;

      assign rem_sh_in = {rt_rem_ff[j], rt_v_ff[j][SUM_W-1 -: 2]};
      assign trial_in  = {2'b00, rt_root_ff[j], 2'b01};
      assign take_in   = rem_sh_in >= trial_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            rt_vld_ff[j+1] <= rt_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_v_ff[j+1]    <= {rt_v_ff[j][SUM_W-3:0], 2'b00};
            rt_rem_ff[j+1]  <= take_in ? REM_W'(rem_sh_in - trial_in) : REM_W'(rem_sh_in);
            rt_root_ff[j+1] <= {rt_root_ff[j][ROOT_W-2:0], take_in};
            for (int k = 0; k < NUM_COMP; k++) begin
               rt_mag_ff[j+1][k] <= rt_mag_ff[j][k];
               rt_neg_ff[j+1][k] <= rt_neg_ff[j][k];
            end
         end
      end
   end

   always_comb begin
      dv_vld_ff[0]  = rt_vld_ff[SQRT_STAGES];
      dv_len_ff[0]  = rt_root_ff[SQRT_STAGES];
      // zero length always fails, so the divider never sees a zero divisor in use
      dv_fail_ff[0] = (rt_root_ff[SQRT_STAGES] == '0)
                      || (rt_root_ff[SQRT_STAGES] < min_length_ff);
      for (int k = 0; k < NUM_COMP; k++) begin
         dv_rem_ff[0][k] = rt_mag_ff[SQRT_STAGES][k];
         dv_q_ff[0][k]   = '0;
         dv_neg_ff[0][k] = rt_neg_ff[SQRT_STAGES][k];
      end
   end

   // restoring division of mag * 2^30 by length; magnitude <= length,
   // so the first stage compares unshifted and the rest shift in zeros
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic [DATA_W:0] rem_sh_in [NUM_COMP];
      logic            take_in   [NUM_COMP];

      for (genvar k = 0; k < NUM_COMP; k++) begin : g_comp
         if (i == 0) begin : g_first
            assign rem_sh_in[k] = {1'b0, dv_rem_ff[i][k]};
         end else begin : g_next
            assign rem_sh_in[k] = {dv_rem_ff[i][k], 1'b0};
         end
         assign take_in[k] = rem_sh_in[k] >= {1'b0, dv_len_ff[i]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[i+1] <= dv_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[i+1]  <= dv_len_ff[i];
            dv_fail_ff[i+1] <= dv_fail_ff[i];
            for (int k = 0; k < NUM_COMP; k++) begin
               dv_rem_ff[i+1][k] <= take_in[k]
                  ? DATA_W'(rem_sh_in[k] - {1'b0, dv_len_ff[i]})
                  : DATA_W'(rem_sh_in[k]);
               dv_q_ff[i+1][k]   <= {dv_q_ff[i][k][QUO_W-2:0], take_in[k]};
               dv_neg_ff[i+1][k] <= dv_neg_ff[i][k];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_COMP; k++) begin
         if (dv_fail_ff[DIV_STAGES]) begin
            out_in[k] = '0;
         end else if (dv_neg_ff[DIV_STAGES][k]) begin
            out_in[k] = DATA_W'(0) - DATA_W'(dv_q_ff[DIV_STAGES][k]);
         end else begin
            out_in[k] = DATA_W'(dv_q_ff[DIV_STAGES][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ok_ff <= !dv_fail_ff[DIV_STAGES];
         for (int k = 0; k < NUM_COMP; k++) begin
            out_ff[k] <= out_in[k];
         end
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_valid_res = out_ok_ff;
   assign rsp_out_x     = signed'(out_ff[0]);
   assign rsp_out_y     = signed'(out_ff[1]);
   assign rsp_out_z     = signed'(out_ff[2]);

   // a rejected vector comes out as all zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("rejected vector not zero");

   // a normalized x component stays within the unit range (signed compare)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
         rsp_out_x >= -(signed'(DATA_W'(1)) <<< FRAC_BITS)
         && rsp_out_x <= (signed'(DATA_W'(1)) <<< FRAC_BITS))
      else $error("x component out of unit range");

   // no word can reach the output right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("word emerged right after reset");

endmodule
